// ----- rtl/psfq_pkg.sv -----
// Package for the packed small-float quantizer.
// Holds float32 constants and default mantissa widths; no dependencies.
package psfq_pkg;
   localparam int RgMantissaBits = 6;
   localparam int BMantissaBits = 5;
   localparam logic [31:0] QnanBits = 32'h7FC00000;
   localparam logic [7:0] MinNormalBexp = 8'd113;
   localparam logic [7:0] MaxBexp = 8'd142;
   localparam logic [7:0] ExpAllOnes = 8'hFF;
endpackage

// ----- rtl/psfq_lane.sv -----
// One channel lane: rounds a float32 onto the small-float grid, registered.
// Depends on psfq_pkg.
module psfq_lane import psfq_pkg::*; #(
   parameter int MANT_BITS = RgMantissaBits
) (
   input  logic        clock,
   input  logic        load,
   input  logic [31:0] x,
   output logic [31:0] y
);
   localparam int M = MANT_BITS;
   localparam logic [31:0] MaxBits = {1'b0, MaxBexp, {M{1'b1}}, {(23 - M){1'b0}}};

   logic [31:0] y_ff, y_in;
   logic [7:0]  bexp;
   logic [22:0] frac;
   logic [23:0] sig;
   logic [5:0]  r;
   logic [23:0] q, rem, half, mask, n;
   logic [31:0] nres;
   logic [4:0]  p;

   assign bexp = x[30:23];
   assign frac = x[22:0];

   always_comb begin
      y_in = 32'd0;
      sig = '0; r = '0; q = '0; rem = '0; half = '0; mask = '0; n = '0;
      nres = '0; p = '0;
      if (bexp == ExpAllOnes) begin
         y_in = QnanBits;
      end else if (x[31] || x[30:0] == 31'd0) begin
         y_in = 32'd0;
      end else if (bexp < MinNormalBexp) begin
         // Shift amount 136-m-e_eff ranges from 23-m+1 up to 135-m.
         sig = (bexp == 8'd0) ? {1'b0, frac} : {1'b1, frac};
         r = (bexp == 8'd0) ? 6'(8'd135 - 8'(M)) : 6'(8'd136 - 8'(M) - bexp);
         if (bexp != 8'd0 && (8'd136 - 8'(M) - bexp) >= 8'd40) r = 6'd40;
         if (bexp == 8'd0 && (8'd135 - 8'(M)) >= 8'd40) r = 6'd40;
         if (r >= 6'd25) begin
            n = '0;
         end else begin
            q = sig >> r;
            mask = (24'd1 << r) - 24'd1;
            rem = sig & mask;
            half = 24'd1 << (r - 6'd1);
            n = q + 24'((rem > half || (rem == half && q[0])) ? 1 : 0);
         end
         if (n == 24'd0) begin
            y_in = 32'd0;
         end else if (n >= (24'd1 << M)) begin
            y_in = {1'b0, MinNormalBexp, 23'd0};
         end else begin
            for (int i = 0; i < M; i++) if (n[i]) p = 5'(i);
            y_in = {1'b0, 8'(MinNormalBexp + 8'(p) - 8'(M)), 23'd0} |
                   32'((n - (24'd1 << p)) << (5'd23 - p));
         end
      end else begin
         sig = {1'b1, frac};
         q = sig >> (23 - M);
         rem = sig & ((24'd1 << (23 - M)) - 24'd1);
         half = 24'd1 << (22 - M);
         n = q + 24'((rem > half || (rem == half && q[0])) ? 1 : 0);
         nres = {1'b0, bexp, 23'd0} + (32'(n - (24'd1 << M)) << (23 - M));
         y_in = (nres > MaxBits) ? MaxBits : nres;
      end
   end

   always_ff @(posedge clock) begin
      if (load) y_ff <= y_in;
   end
   assign y = y_ff;
endmodule

// ----- rtl/packed_small_float_quantizer_unit.sv -----
// Top level of the packed small-float quantizer: three lanes and an output stage.
// Depends on psfq_pkg and psfq_lane.
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_red_in/green_in/blue_in
//   rsp     | out       | rsp_valid, rsp_stall, rsp_red_out/green_out/blue_out
// Each item passes through the lane logic into the output register, so one item
// per clock is sustained while the output is not stalled. Reset clears the output valid only.
// The input stalls only while a held result is stalled and no slot frees up.
module packed_small_float_quantizer_unit import psfq_pkg::*; #(
   parameter int RG_MANTISSA_BITS = RgMantissaBits,
   parameter int B_MANTISSA_BITS = BMantissaBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_red_in,
   input  logic [31:0] req_green_in,
   input  logic [31:0] req_blue_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_red_out,
   output logic [31:0] rsp_green_out,
   output logic [31:0] rsp_blue_out
);
   logic valid_ff, valid_in, load;

   assign req_stall = valid_ff && rsp_stall;
   assign load = req_valid && !req_stall;
   assign valid_in = load ? 1'b1 : (rsp_stall ? valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end
   assign rsp_valid = valid_ff;

   psfq_lane #(.MANT_BITS(RG_MANTISSA_BITS)) u_red (
      .clock(clock), .load(load), .x(req_red_in), .y(rsp_red_out));
   psfq_lane #(.MANT_BITS(RG_MANTISSA_BITS)) u_green (
      .clock(clock), .load(load), .x(req_green_in), .y(rsp_green_out));
   psfq_lane #(.MANT_BITS(B_MANTISSA_BITS)) u_blue (
      .clock(clock), .load(load), .x(req_blue_in), .y(rsp_blue_out));
endmodule

// ----- tb/tb_top.sv -----
// Testbench for packed_small_float_quantizer_unit: directed and random RGB items.
// Depends on psfq_pkg and the quantizer RTL; predicts each channel's rounding itself.
module tb_top;
   import psfq_pkg::*;

   localparam int RgBits = RgMantissaBits;
   localparam int BBits = BMantissaBits;

   typedef struct packed {
      logic [31:0] red;
      logic [31:0] green;
      logic [31:0] blue;
   } rgb_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [31:0] req_red_in = '0;
   logic [31:0] req_green_in = '0;
   logic [31:0] req_blue_in = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_red_out;
   logic [31:0] rsp_green_out;
   logic [31:0] rsp_blue_out;

   rgb_type pixel_queue[$];
   rgb_type quantized_queue[$];
   int error_count = 0;
   bit stimulus_done = 1'b0;
   bit req_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int stall_mode = 0;

   packed_small_float_quantizer_unit uut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // Round v / 2^r to nearest, ties to even.
   function automatic logic [63:0] round_shift(logic [63:0] v, int r);
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      if (r == 0) return v;
      if (r >= 40) return 64'd0;
      q = v >> r;
      rem = v & ((64'd1 << r) - 64'd1);
      half = 64'd1 << (r - 1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
      return q;
   endfunction

   function automatic logic [31:0] quantize_lane(logic [31:0] x, int m);
      logic [7:0] bexp;
      logic [31:0] eff;
      logic [63:0] sig;
      logic [63:0] n;
      logic [31:0] max_bits;
      logic [31:0] res;
      int r;
      int p;
      bexp = x[30:23];
      max_bits = ({24'd0, MaxBexp} << 23) | (((32'd1 << m) - 32'd1) << (23 - m));
      if (bexp == ExpAllOnes) return QnanBits;
      if (x[31] || x[30:0] == 31'd0) return 32'd0;
      if (bexp < MinNormalBexp) begin
         eff = (bexp == 8'd0) ? 32'd1 : {24'd0, bexp};
         sig = (bexp == 8'd0) ? {41'd0, x[22:0]} : {41'd1, x[22:0]};
         r = 136 - m - int'(eff);
         n = round_shift(sig, r);
         if (n == 64'd0) return 32'd0;
         if (n >= (64'd1 << m)) return {24'd0, MinNormalBexp} << 23;
         p = 0;
         while (p < 31 && (n >> (p + 1)) != 64'd0) p++;
         res = ((32'(MinNormalBexp) + p - m) << 23) |
               ((n[31:0] - (32'd1 << p)) << (23 - p));
         return res;
      end
      sig = {41'd1, x[22:0]};
      r = 23 - m;
      n = round_shift(sig, r);
      res = ({24'd0, bexp} << 23) + (32'(n - (64'd1 << m)) << r);
      if (res > max_bits) res = max_bits;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      error_count++;
   endtask

   // Random float32 pattern biased toward the interesting exponent ranges.
   function automatic logic [31:0] random_float();
      logic [31:0] v;
      int sel;
      sel = $urandom_range(0, 9);
      v = $urandom;
      case (sel)
         0: v = v;
         1: v[30:23] = 8'(($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00);
         2, 3: v[30:23] = 8'($urandom_range(98, 112));
         default: v[30:23] = 8'($urandom_range(112, 143));
      endcase
      if (sel != 0 && $urandom_range(0, 3) != 0) v[31] = 1'b0;
      return v;
   endfunction

   initial begin
      logic [31:0] edge_vals[$];
      rgb_type px;
      edge_vals = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                    32'h7FC0_0001, 32'h0000_0001, 32'h007F_FFFF, 32'h3880_0000,
                    32'h387F_FFFF, 32'h3800_0000, 32'h3F80_0000, 32'h3F81_0000,
                    32'h3F83_0000, 32'h3FFF_FFFF, 32'h477F_FFFF, 32'h4780_0000,
                    32'h7F7F_FFFF, 32'hBF80_0000, 32'h3F7E_0000, 32'hFFFF_FFFF};
      foreach (edge_vals[i]) begin
         px.red = edge_vals[i];
         px.green = edge_vals[(i + 3) % edge_vals.size()];
         px.blue = edge_vals[(i + 7) % edge_vals.size()];
         pixel_queue.push_back(px);
      end
      for (int i = 0; i < 600; i++) begin
         px.red = random_float();
         px.green = random_float();
         px.blue = random_float();
         pixel_queue.push_back(px);
      end
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      stimulus_done = 1'b1;
   end

   task automatic px_drive();
      rgb_type px;
      px = pixel_queue.pop_front();
      req_valid <= 1'b1;
      req_red_in <= px.red;
      req_green_in <= px.green;
      req_blue_in <= px.blue;
      if (burst_left <= 1) begin
         burst_left <= $urandom_range(1, 20);
         gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      end else begin
         burst_left <= burst_left - 1;
      end
   endtask

   // Sender: bursts with gaps; an item not taken at the last rising edge is held.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pixel_queue.size() > 0) begin
            px_drive();
         end else begin
            req_valid <= 1'b0;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
         if ($urandom_range(0, 40) == 0) stall_mode <= $urandom_range(0, 2);
      end
   end

   // Monitor: predict on input acceptance, compare on output acceptance.
   always @(posedge clock) begin
      rgb_type want;
      req_taken <= 1'b0;
      if (!reset) begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            want.red = quantize_lane(req_red_in, RgBits);
            want.green = quantize_lane(req_green_in, RgBits);
            want.blue = quantize_lane(req_blue_in, BBits);
            quantized_queue.push_back(want);
         end
         if (rsp_valid && !rsp_stall) begin
            if (quantized_queue.size() == 0) begin
               $display("unexpected item: %h %h %h", rsp_red_out, rsp_green_out,
                        rsp_blue_out);
               error_count++;
            end else begin
               want = quantized_queue.pop_front();
               if (rsp_red_out !== want.red) report_mismatch("red", rsp_red_out, want.red);
               if (rsp_green_out !== want.green)
                  report_mismatch("green", rsp_green_out, want.green);
               if (rsp_blue_out !== want.blue)
                  report_mismatch("blue", rsp_blue_out, want.blue);
            end
         end
      end
   end

   initial begin
      wait (stimulus_done);
      wait (pixel_queue.size() == 0 && !req_valid);
      wait (quantized_queue.size() == 0);
      repeat (10) @(posedge clock);
      if (error_count == 0 && quantized_queue.size() == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("tb_top: done, errors");
      $finish;
   end
endmodule
